// ----- design/agt_pkg.sv -----
// ----------------------------------------------------------------------------
// agt_pkg: shared types and constants of the access gap tracker
// Widths of the address, clock and table, and the table write word.
// ----------------------------------------------------------------------------
`default_nettype none

package agt_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int ADDR_W      = 16;
   localparam int MAX_ADDR_W  = 13;
   localparam int CLK_W       = 31;
   localparam int DIST_W      = 32;
   localparam int DEPTH_W     = $clog2(TABLE_DEPTH + 1);
   // compare width wide enough for the address and for the table depth itself
   localparam int CMP_W       = (DEPTH_W > ADDR_W) ? DEPTH_W : ADDR_W;

   localparam logic [MAX_ADDR_W-1:0] MAX_ADDR_RESET = MAX_ADDR_W'(4096);
   localparam logic [CLK_W-1:0]      CLOCK_MAX      = '1;
   localparam logic [CLK_W-1:0]      CLOCK_START    = CLK_W'(1);
   localparam logic [CLK_W-1:0]      NEVER_SEEN     = '0;
   localparam logic [DIST_W-1:0]     DIST_FIRST     = '1;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [CLK_W-1:0] data;
   } wr_req_type;

endpackage

`default_nettype wire

// ----- design/agt_if.sv -----
// ----------------------------------------------------------------------------
// agt_if: channel interfaces of the access gap tracker
// Access request, gap response and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface agt_req_if;
   logic                      valid;
   logic                      ready;
   logic [agt_pkg::ADDR_W-1:0] addr;
   logic                      end_of_batch;

   modport source (output valid, output addr, output end_of_batch, input ready);
   modport sink   (input valid, input addr, input end_of_batch, output ready);
endinterface

interface agt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [agt_pkg::DIST_W-1:0] distance;
   logic                              range_error;
   logic                              last_of_batch;

   modport source (output valid, output distance, output range_error,
                   output last_of_batch, input ready);
   modport sink   (input valid, input distance, input range_error,
                   input last_of_batch, output ready);
endinterface

interface agt_csr_if;
   logic                          valid;
   logic                          ready;
   logic [agt_pkg::MAX_ADDR_W-1:0] max_addr;

   modport source (output valid, output max_addr, input ready);
   modport sink   (input valid, input max_addr, output ready);
endinterface

`default_nettype wire

// ----- design/agt_stamp_ram.sv -----
// ----------------------------------------------------------------------------
// agt_stamp_ram: last-access time table
// One write and one registered read per cycle, write-first on a same-cycle
// collision, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module agt_stamp_ram (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        rd_en,
   input  wire logic [agt_pkg::IDX_W-1:0]   rd_addr,
   output logic      [agt_pkg::CLK_W-1:0]   rd_data,
   input  wire agt_pkg::wr_req_type         wr,
   output logic                             busy
);

   logic [agt_pkg::CLK_W-1:0] mem [agt_pkg::TABLE_DEPTH];

   logic                      clr_busy_ff;
   logic [agt_pkg::IDX_W-1:0] clr_cnt_ff;
   logic [agt_pkg::CLK_W-1:0] ram_q_ff;
   logic                      fwd_hit_ff;
   logic [agt_pkg::CLK_W-1:0] fwd_data_ff;

   logic                      mem_we;
   logic [agt_pkg::IDX_W-1:0] mem_waddr;
   logic [agt_pkg::CLK_W-1:0] mem_wdata;

   always_comb begin
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = agt_pkg::NEVER_SEEN;
      end else begin
         mem_we    = wr.en;
         mem_waddr = wr.addr;
         mem_wdata = wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == agt_pkg::IDX_W'(agt_pkg::TABLE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         ram_q_ff    <= mem[rd_addr];
         fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
         fwd_data_ff <= wr.data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : ram_q_ff;
   assign busy    = clr_busy_ff;

   a_collision_write_first: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr.en && (wr.addr == rd_addr) |=> rd_data == $past(wr.data))
      else $error("read colliding with a write did not return the new stamp");

   a_no_pipe_write_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !wr.en && !rd_en)
      else $error("table accessed during clearing sweep");

   a_clear_done_stays_done: assert property (@(posedge clock) disable iff (reset)
      !clr_busy_ff |=> !clr_busy_ff)
      else $error("clearing sweep restarted without a reset");

endmodule

`default_nettype wire

// ----- design/access_gap_tracker.sv -----
// ----------------------------------------------------------------------------
// access_gap_tracker: reuse-distance tracker
// Reports for each address the accesses since its previous access (-1 on a
// first access) and stamps a last-access table with a saturating clock.
// ----------------------------------------------------------------------------
//  channel  dir  word                                       accepted when
//  req      in   addr, end_of_batch                         req.valid & req.ready
//  rsp      out  distance, range_error, last_of_batch       rsp.valid & rsp.ready
//  csr      in   max_addr                                   csr.valid & csr.ready
//
//  one word per cycle while rsp is not stalled; from req accept to rsp valid
//  a word passes the table read register, then the result register
//  after reset a clearing sweep over all 4096 entries zeroes the table; req.ready
//  stays low during it, csr writes are taken throughout
//  a stalled rsp holds the result and one more word in the read stage
// ----------------------------------------------------------------------------
`default_nettype none

module access_gap_tracker (
   input  wire logic clock,
   input  wire logic reset,
   agt_req_if.sink   req,
   agt_rsp_if.source rsp,
   agt_csr_if.sink   csr
);

   logic [agt_pkg::MAX_ADDR_W-1:0] max_addr_ff;
   logic [agt_pkg::CLK_W-1:0]      clock_ff;
   logic [agt_pkg::CLK_W-1:0]      clock_in;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic [agt_pkg::ADDR_W-1:0] s1_addr_ff;
   logic                       s1_eob_ff;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [agt_pkg::DIST_W-1:0] rsp_dist_ff;
   logic signed [agt_pkg::DIST_W-1:0] rsp_dist_in;
   logic                              rsp_err_ff;
   logic                              rsp_eob_ff;

   logic                      accept;
   logic                      s1_adv;
   logic                      s1_err;
   logic [agt_pkg::CMP_W-1:0] s1_addr_ext;
   logic [agt_pkg::CMP_W-1:0] req_addr_ext;
   logic [agt_pkg::CLK_W-1:0] last_stamp;
   logic                      ram_busy;
   agt_pkg::wr_req_type       wr;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !ram_busy && (!s1_valid_ff || s1_adv);
   assign accept     = req.valid && req.ready;
   assign csr.ready  = 1'b1;

   assign req_addr_ext = agt_pkg::CMP_W'(req.addr);
   assign s1_addr_ext  = agt_pkg::CMP_W'(s1_addr_ff);

   // limit is the smaller of max_addr and the table depth
   assign s1_err = (s1_addr_ext >= agt_pkg::CMP_W'(max_addr_ff)) ||
                   (s1_addr_ext >= agt_pkg::CMP_W'(agt_pkg::TABLE_DEPTH));

   agt_stamp_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_addr_ext[agt_pkg::IDX_W-1:0]),
      .rd_data (last_stamp),
      .wr      (wr),
      .busy    (ram_busy)
   );

   always_comb begin
      wr.en   = s1_adv && !s1_err;
      wr.addr = s1_addr_ext[agt_pkg::IDX_W-1:0];
      wr.data = clock_ff;
   end

   always_comb begin
      if (s1_err) begin
         rsp_dist_in = '0;
      end else if (last_stamp == agt_pkg::NEVER_SEEN) begin
         rsp_dist_in = agt_pkg::DIST_FIRST;
      end else begin
         rsp_dist_in = {1'b0, clock_ff - last_stamp};
      end
   end

   always_comb begin
      clock_in = clock_ff;
      if (wr.en && (clock_ff != agt_pkg::CLOCK_MAX)) begin
         clock_in = clock_ff + 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_addr_ff  <= agt_pkg::MAX_ADDR_RESET;
         clock_ff     <= agt_pkg::CLOCK_START;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            max_addr_ff <= csr.max_addr;
         end
         clock_ff     <= clock_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= req.addr;
         s1_eob_ff  <= req.end_of_batch;
      end
      if (s1_adv) begin
         rsp_dist_ff <= rsp_dist_in;
         rsp_err_ff  <= s1_err;
         rsp_eob_ff  <= s1_eob_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.distance      = rsp_dist_ff;
   assign rsp.range_error   = rsp_err_ff;
   assign rsp.last_of_batch = rsp_eob_ff;

   a_clock_never_zero: assert property (@(posedge clock) disable iff (reset)
      clock_ff != agt_pkg::NEVER_SEEN)
      else $error("access clock reached the never-seen value");

   a_clock_advance: assert property (@(posedge clock) disable iff (reset)
      wr.en && (clock_ff != agt_pkg::CLOCK_MAX) |=> clock_ff == $past(clock_ff) + 1'b1)
      else $error("access clock did not advance after a stamped access");

   a_error_zero_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_dist_ff == '0)
      else $error("range error word carries a nonzero distance");

   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      ram_busy |-> !req.ready && !s1_valid_ff)
      else $error("word taken during table clearing sweep");

endmodule

`default_nettype wire

// ----- tb/agt_gap_checker.sv -----
// ----------------------------------------------------------------------------
// agt_gap_checker: reuse-distance predictor and response checker
// Watches the request, response and register channels of the access gap
// tracker. It keeps its own last-access table and access clock, works out
// the word due for every accepted request and compares each accepted
// response with the oldest word still due.
// ----------------------------------------------------------------------------
module agt_gap_checker
   import agt_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [ADDR_W-1:0]            req_addr,
   input  logic                         req_end_of_batch,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [DIST_W-1:0]     rsp_distance,
   input  logic                         rsp_range_error,
   input  logic                         rsp_last_of_batch,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [MAX_ADDR_W-1:0]        csr_max_addr,
   output int                           pending,
   output int                           failures
);

   typedef struct packed {
      logic signed [DIST_W-1:0] distance;
      logic                     range_error;
      logic                     last_of_batch;
   } gap_word_type;

   logic [CLK_W-1:0]      last_stamp [0:TABLE_DEPTH-1];
   logic [CLK_W-1:0]      access_count;
   logic [MAX_ADDR_W-1:0] max_addr_q;
   gap_word_type          gaps_due [$];

   function automatic gap_word_type track_access(input logic [ADDR_W-1:0] addr,
                                                 input logic eob);
      gap_word_type w;
      int           lim;
      lim = (int'(max_addr_q) > TABLE_DEPTH) ? TABLE_DEPTH : int'(max_addr_q);
      w.last_of_batch = eob;
      if (int'(addr) >= lim) begin
         w.distance    = '0;
         w.range_error = 1'b1;
      end else begin
         w.range_error = 1'b0;
         if (last_stamp[addr[IDX_W-1:0]] == NEVER_SEEN) begin
            w.distance = DIST_FIRST;
         end else begin
            // 31-bit difference; the clock saturates and does not wrap
            w.distance = {1'b0, access_count - last_stamp[addr[IDX_W-1:0]]};
         end
         last_stamp[addr[IDX_W-1:0]] = access_count;
         if (access_count != CLOCK_MAX) begin
            access_count = access_count + 1'b1;
         end
      end
      return w;
   endfunction

   always @(posedge clock) begin : watch
      gap_word_type want;
      int           i;
      if (reset) begin
         for (i = 0; i < TABLE_DEPTH; i++) begin
            last_stamp[i] = NEVER_SEEN;
         end
         access_count = CLOCK_START;
         max_addr_q   = MAX_ADDR_RESET;
         gaps_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            max_addr_q = csr_max_addr;
         end
         if (rsp_valid && rsp_ready) begin
            if (gaps_due.size() == 0) begin
               failures++;
               $display("%0t: response word with none due (distance %0d)", $time,
                        $signed(rsp_distance));
            end else begin
               want = gaps_due.pop_front();
               if (rsp_distance !== want.distance) begin
                  failures++;
                  $display("%0t: distance expected %0d got %0d", $time,
                           $signed(want.distance), $signed(rsp_distance));
               end
               if (rsp_range_error !== want.range_error) begin
                  failures++;
                  $display("%0t: range_error expected %0b got %0b", $time,
                           want.range_error, rsp_range_error);
               end
               if (rsp_last_of_batch !== want.last_of_batch) begin
                  failures++;
                  $display("%0t: last_of_batch expected %0b got %0b", $time,
                           want.last_of_batch, rsp_last_of_batch);
               end
            end
         end
         if (req_valid && req_ready) begin
            gaps_due.push_back(track_access(req_addr, req_end_of_batch));
         end
      end
      pending <= gaps_due.size();
   end

endmodule

// ----- tb/access_gap_tracker_test.sv -----
// ----------------------------------------------------------------------------
// access_gap_tracker_test: stimulus and verdict for the access gap tracker
// Writes max_addr across its range, sends directed and random access words
// with random gaps and response stalls, and leaves the checking to
// agt_gap_checker.
// ----------------------------------------------------------------------------
module access_gap_tracker_test;
   import agt_pkg::*;

   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ACCESSES = 125;

   logic clock = 1'b0;
   logic reset;

   int tx_idle_pct;
   int rx_idle_pct;
   int holds_asked;
   int outstanding;
   int mismatches;

   agt_req_if req_ch ();
   agt_rsp_if rsp_ch ();
   agt_csr_if csr_ch ();

   access_gap_tracker u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   agt_gap_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_addr          (req_ch.addr),
      .req_end_of_batch  (req_ch.end_of_batch),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_distance      (rsp_ch.distance),
      .rsp_range_error   (rsp_ch.range_error),
      .rsp_last_of_batch (rsp_ch.last_of_batch),
      .csr_valid         (csr_ch.valid),
      .csr_ready         (csr_ch.ready),
      .csr_max_addr      (csr_ch.max_addr),
      .pending           (outstanding),
      .failures          (mismatches)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #1000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // response side: random stalls, plus long hold-offs on request
   initial begin : rsp_drive
      int holds_served;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_asked != holds_served) begin
            holds_served++;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_access(input logic [ADDR_W-1:0] a, input logic eob);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.addr         <= a;
      req_ch.end_of_batch <= eob;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // only written with nothing in flight
   task automatic set_max_addr(input logic [MAX_ADDR_W-1:0] v);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_ch.valid    <= 1'b1;
      csr_ch.max_addr <= v;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // mostly a small hot set so that gaps repeat, some near and past the limit
   function automatic logic [ADDR_W-1:0] pick_addr(input int lim);
      int r;
      r = $urandom_range(99);
      if (lim > 0 && r < 55) return ADDR_W'($urandom_range(((lim < 24) ? lim : 24) - 1));
      if (lim > 0 && r < 65)
         return ADDR_W'(lim - 1 - int'($urandom_range((lim < 8) ? lim - 1 : 7)));
      if (lim > 0 && r < 85) return ADDR_W'($urandom_range(lim - 1));
      if (r < 92) return ADDR_W'(lim + int'($urandom_range(2)));
      return ADDR_W'($urandom_range(65535));
   endfunction

   initial begin : stimulus
      int                    ph;
      int                    n;
      int                    lim;
      logic [MAX_ADDR_W-1:0] mv;
      tx_idle_pct = 37;
      rx_idle_pct = 59;
      holds_asked = 0;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.addr         <= '0;
      req_ch.end_of_batch <= 1'b0;
      csr_ch.valid        <= 1'b0;
      csr_ch.max_addr     <= MAX_ADDR_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // register above the table depth: limit falls back to the depth
      set_max_addr(13'd8191);
      send_access(16'd0, 1'b0);
      send_access(16'd0, 1'b0);
      send_access(16'd4095, 1'b0);
      send_access(16'd4096, 1'b0);
      send_access(16'hFFFF, 1'b1);
      send_access(16'd8191, 1'b0);
      send_access(16'd4095, 1'b0);
      send_access(16'd0, 1'b0);
      send_access(16'd1, 1'b1);
      send_access(16'h8000, 1'b0);
      send_access(16'h0AAA, 1'b0);
      send_access(16'h0555, 1'b0);
      send_access(16'h0AAA, 1'b1);
      send_access(16'h5555, 1'b0);
      // limit zero: every address is rejected
      set_max_addr(13'd0);
      send_access(16'd0, 1'b0);
      send_access(16'd4095, 1'b1);
      // limit one: only address 0 gets through
      set_max_addr(13'd1);
      send_access(16'd0, 1'b0);
      send_access(16'd1, 1'b0);
      send_access(16'd0, 1'b1);
      set_max_addr(MAX_ADDR_RESET);
      send_access(16'd4095, 1'b0);
      send_access(16'd4096, 1'b0);
      send_access(16'd1, 1'b0);

      for (ph = 0; ph < 9; ph++) begin
         if (ph == 3) begin
            tx_idle_pct = 59;
            rx_idle_pct = 37;
         end else if (ph == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         case (ph)
            0:       mv = 13'd4096;
            1:       mv = 13'd64;
            2:       mv = 13'd8191;
            3:       mv = 13'd1;
            4:       mv = 13'd2000;
            5:       mv = 13'd0;
            6:       mv = 13'd4095;
            7:       mv = 13'd300;
            default: mv = 13'd4096;
         endcase
         set_max_addr(mv);
         lim = (int'(mv) > TABLE_DEPTH) ? TABLE_DEPTH : int'(mv);
         if (ph == 1 || ph == 7) holds_asked++;
         for (n = 0; n < PHASE_ACCESSES; n++) begin
            send_access(pick_addr(lim), ($urandom_range(7) == 0));
         end
      end

      req_ch.valid <= 1'b0;
      rx_idle_pct = 0;
      do @(posedge clock); while (outstanding != 0);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/agt_pkg.sv
design/agt_if.sv
design/agt_stamp_ram.sv
design/access_gap_tracker.sv
tb/agt_gap_checker.sv
tb/access_gap_tracker_test.sv
